[hdl/hgu_pkg.sv]
// Shared types, constants and codes for the HTTP GET URL classifier.
`timescale 1ns / 1ps

package hgu_pkg;

   localparam int URL_LIMIT_DEFAULT   = 192;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [31:0] METHOD_GET     = 32'h47455420;
   localparam logic [63:0] FNV_BASIS      = 64'hcbf29ce484222325;

   localparam logic [7:0] CHAR_SP = 8'h20;
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   localparam logic [15:0] PORT_A_RESET = 16'd80;
   localparam logic [15:0] PORT_B_RESET = 16'd8080;
   localparam logic [15:0] PORT_C_RESET = 16'd3000;

   localparam logic [1:0] REG_PORT_A = 2'd0;
   localparam logic [1:0] REG_PORT_B = 2'd1;
   localparam logic [1:0] REG_PORT_C = 2'd2;

   typedef enum logic [2:0] {
      V_GET       = 3'd0,
      V_NOT_IPV4  = 3'd1,
      V_NOT_TCP   = 3'd2,
      V_UNWATCHED = 3'd3,
      V_MALFORMED = 3'd4,
      V_NOT_GET   = 3'd5,
      V_EMPTY_URL = 3'd6
   } verdict_type;

   typedef enum logic [2:0] {
      PH_ETH    = 3'd0,
      PH_IP     = 3'd1,
      PH_TCP    = 3'd2,
      PH_METHOD = 3'd3,
      PH_URL    = 3'd4,
      PH_DONE   = 3'd5
   } phase_type;

   // work item handed from the parser to the hash/result stage
   typedef struct packed {
      logic        hash_en;
      logic        last;
      logic [7:0]  data;
      verdict_type verdict;
      logic [15:0] port;
      logic [7:0]  url_len;
   } tok_type;

endpackage

[hdl/hgu_front.sv]
// Frame parser: walks the headers, classifies each beat and emits hash/end tokens.
`timescale 1ns / 1ps

module hgu_front #(
   parameter int URL_LIMIT = hgu_pkg::URL_LIMIT_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_wdata,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,
   input  logic             req_tlast,
   output logic             tok_valid,
   input  logic             tok_ready,
   output hgu_pkg::tok_type tok
);
   import hgu_pkg::*;

   localparam int CW = $clog2(URL_LIMIT + 1);

   logic [15:0] port_a_ff, port_b_ff, port_c_ff;
   phase_type   phase_ff, phase_in;
   logic [15:0] pos_ff, pos_in;
   logic [3:0]  ihl_ff, ihl_in;
   logic [3:0]  off_ff, off_in;
   logic [15:0] port_ff, port_in;
   logic [31:0] ms_ff, ms_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   verdict_type vh_ff, vh_in;
   logic        hash_en;
   logic        stop;
   logic        fire;
   logic [7:0]  b;

   assign b          = req_tdata;
   assign req_tready = tok_ready;
   assign fire       = req_tvalid && tok_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         port_a_ff <= PORT_A_RESET;
         port_b_ff <= PORT_B_RESET;
         port_c_ff <= PORT_C_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_PORT_A: port_a_ff <= csr_wdata;
            REG_PORT_B: port_b_ff <= csr_wdata;
            REG_PORT_C: port_c_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      ihl_in   = ihl_ff;
      off_in   = off_ff;
      port_in  = port_ff;
      ms_in    = ms_ff;
      cnt_in   = cnt_ff;
      vh_in    = vh_ff;
      hash_en  = 1'b0;
      stop     = 1'b0;
      unique case (phase_ff)
         PH_ETH: begin
            ms_in = {ms_ff[23:0], b};
            if (pos_ff == 16'd13) begin
               if (ms_in[15:0] != ETHERTYPE_IPV4) begin
                  vh_in    = V_NOT_IPV4;
                  phase_in = PH_DONE;
               end else begin
                  phase_in = PH_IP;
                  pos_in   = '0;
                  ms_in    = '0;
               end
            end
         end
         PH_IP: begin
            if (pos_ff == 16'd0) ihl_in = b[3:0];
            if (pos_ff == 16'd0 && b[3:0] < 4'd5) begin
               vh_in    = V_MALFORMED;
               phase_in = PH_DONE;
            end else begin
               if (pos_ff == 16'd9) ms_in = {31'd0, b != PROTO_TCP};
               if (pos_ff == 16'd19 && ms_in != 32'd0) begin
                  vh_in    = V_NOT_TCP;
                  phase_in = PH_DONE;
               end else if (pos_ff >= 16'd19 &&
                            pos_ff == {10'd0, ihl_in, 2'b00} - 16'd1) begin
                  phase_in = PH_TCP;
                  pos_in   = '0;
                  ms_in    = '0;
               end
            end
         end
         PH_TCP: begin
            if (pos_ff == 16'd2 || pos_ff == 16'd3) ms_in = {ms_ff[23:0], b};
            if (pos_ff == 16'd12) off_in = b[7:4];
            if (pos_ff == 16'd19) begin
               port_in = ms_in[15:0];
               if (port_in != port_a_ff && port_in != port_b_ff &&
                   port_in != port_c_ff) begin
                  vh_in    = V_UNWATCHED;
                  phase_in = PH_DONE;
                  stop     = 1'b1;
               end else if (off_in < 4'd5) begin
                  vh_in    = V_MALFORMED;
                  phase_in = PH_DONE;
                  stop     = 1'b1;
               end
            end
            if (!stop && pos_ff >= 16'd19 &&
                pos_ff == {10'd0, off_in, 2'b00} - 16'd1) begin
               phase_in = PH_METHOD;
               pos_in   = '0;
               ms_in    = '0;
            end
         end
         PH_METHOD: begin
            ms_in = {ms_ff[23:0], b};
            if (pos_ff == 16'd3) begin
               if (ms_in == METHOD_GET) begin
                  phase_in = PH_URL;
                  pos_in   = '0;
                  ms_in    = '0;
                  cnt_in   = '0;
                  vh_in    = V_EMPTY_URL;
               end else begin
                  vh_in    = V_NOT_GET;
                  phase_in = PH_DONE;
               end
            end
         end
         PH_URL: begin
            if (b == CHAR_SP || b == CHAR_CR || b == CHAR_LF) begin
               phase_in = PH_DONE;
            end else begin
               hash_en = 1'b1;
               cnt_in  = cnt_ff + 1'b1;
               vh_in   = V_GET;
               if (cnt_in >= CW'(URL_LIMIT)) phase_in = PH_DONE;
            end
         end
         default: ;
      endcase
      if (phase_in == phase_ff && pos_ff != 16'hFFFF) pos_in = pos_in + 16'd1;
   end

   assign tok_valid   = req_tvalid && (hash_en || req_tlast);
   assign tok.hash_en = hash_en;
   assign tok.last    = req_tlast;
   assign tok.data    = b;
   assign tok.verdict = vh_in;
   assign tok.port    = port_in;
   assign tok.url_len = 8'(cnt_in);

   always_ff @(posedge clock) begin
      if (reset || (fire && req_tlast)) begin
         phase_ff <= PH_ETH;
         pos_ff   <= '0;
         ihl_ff   <= '0;
         off_ff   <= '0;
         port_ff  <= '0;
         ms_ff    <= '0;
         cnt_ff   <= '0;
         vh_ff    <= V_MALFORMED;
      end else if (fire) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         ihl_ff   <= ihl_in;
         off_ff   <= off_in;
         port_ff  <= port_in;
         ms_ff    <= ms_in;
         cnt_ff   <= cnt_in;
         vh_ff    <= vh_in;
      end
   end

endmodule

[hdl/hgu_queue.sv]
// Short token queue between the parser and the hash/result stage.
`timescale 1ns / 1ps

module hgu_queue #(
   parameter int DEPTH = hgu_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  hgu_pkg::tok_type push_tok,
   output logic             pop_valid,
   input  logic             pop_ready,
   output hgu_pkg::tok_type pop_tok
);
   import hgu_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   tok_type       slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic          push, pop;

   assign push_ready = count_ff != CW'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_tok    = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_tok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

endmodule

[hdl/hgu_back.sv]
// Hash and result stage: FNV-1a over URL tokens, frame counter, response register.
`timescale 1ns / 1ps

module hgu_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             tok_valid,
   output logic             tok_ready,
   input  hgu_pkg::tok_type tok,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [151:0]     rsp_tdata,
   output logic [2:0]       rsp_tuser
);
   import hgu_pkg::*;

   // multiply by the FNV prime 2^40 + 0x1b3 as shifts and adds
   function automatic logic [63:0] fnv_mul(input logic [63:0] h);
      fnv_mul = h + (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1);
   endfunction

   logic [63:0]  hash_ff, hash_mid;
   logic [63:0]  frames_ff;
   logic         valid_ff;
   verdict_type  verdict_ff;
   logic [15:0]  port_ff;
   logic [7:0]   len_ff;
   logic [63:0]  hout_ff;
   logic [63:0]  fout_ff;
   logic         pop, hit;

   assign tok_ready = !tok.last || !valid_ff || rsp_tready;
   assign pop       = tok_valid && tok_ready;
   assign hash_mid  = tok.hash_en ? fnv_mul(hash_ff ^ {56'd0, tok.data}) : hash_ff;
   assign hit       = tok.verdict == V_GET;

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff   <= FNV_BASIS;
         frames_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         if (pop && tok.last) valid_ff <= 1'b1;
         else if (rsp_tready) valid_ff <= 1'b0;
         if (pop) begin
            if (tok.last) begin
               hash_ff   <= FNV_BASIS;
               frames_ff <= frames_ff + 64'd1;
            end else begin
               hash_ff <= hash_mid;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && tok.last) begin
         verdict_ff <= tok.verdict;
         port_ff    <= tok.port;
         len_ff     <= hit ? tok.url_len : 8'd0;
         hout_ff    <= hit ? hash_mid : 64'd0;
         fout_ff    <= frames_ff + 64'd1;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = verdict_ff;
   assign rsp_tdata  = {fout_ff, hout_ff, len_ff, port_ff};

endmodule

[hdl/http_get_url_classifier_top.sv]
// Top level of the HTTP GET URL classifier.
`timescale 1ns / 1ps

// Takes one Ethernet frame byte per beat on req_ and gives one verdict beat on rsp_ for
// each frame, carrying the TCP destination port, the URL length, its 64-bit FNV-1a
// hash (both zero unless the verdict is GET matched) and the running frame count.
// Unless the token queue is full, a byte is taken every cycle and the parser advances
// one byte per cycle; the hash stage folds one URL byte per cycle through a
// shift-and-add multiply by the FNV prime. A token queue between parser and hash
// stage absorbs a held response; req_tready drops only when that queue is full.
// The user must write watched ports on csr_ while the block is idle; nothing checks it.
module http_get_url_classifier_top #(
   parameter int URL_LIMIT   = hgu_pkg::URL_LIMIT_DEFAULT,
   parameter int QUEUE_DEPTH = hgu_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] frame_byte
   input  logic         req_tlast,   // end_of_frame
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [15:0] dest_port, [23:16] url_length, [87:24] url_hash, [151:88] frames_seen
   output logic [151:0] rsp_tdata,
   output logic [2:0]   rsp_tuser    // [2:0] verdict
);
   import hgu_pkg::*;

   tok_type push_tok, pop_tok;
   logic    push_valid, push_ready, pop_valid, pop_ready;

   hgu_front #(.URL_LIMIT(URL_LIMIT)) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .tok_valid  (push_valid),
      .tok_ready  (push_ready),
      .tok        (push_tok)
   );

   hgu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_tok   (push_tok),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_tok    (pop_tok)
   );

   hgu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .tok_valid  (pop_valid),
      .tok_ready  (pop_ready),
      .tok        (pop_tok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // input stalls only behind a full queue
   a_stall_means_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> pop_valid)
      else $error("input stalled with empty token queue");

   // a non-matching verdict never carries URL data
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != V_GET) |-> (rsp_tdata[87:16] == 72'd0))
      else $error("URL fields set on a non-GET verdict");

   // a matched URL has at least one byte
   a_get_nonempty: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == V_GET && URL_LIMIT < 256) |-> (rsp_tdata[23:16] != 8'd0))
      else $error("GET verdict with zero URL length");

endmodule

[tb/hgu_verdict_checker.sv]
// Verdict predictor and scoreboard for the HTTP GET URL classifier.
`timescale 1ns / 1ps

module hgu_verdict_checker #(
   parameter int URL_LIMIT = hgu_pkg::URL_LIMIT_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [7:0]   req_tdata,
   input  logic         req_tlast,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [151:0] rsp_tdata,
   input  logic [2:0]   rsp_tuser,
   output int           fail_count,
   output int           pending,
   output int           checked,
   output logic [6:0]   verdicts_seen
);
   import hgu_pkg::*;

   localparam logic [63:0] HASH_MULT = 64'h100000001b3;

   typedef struct packed {
      verdict_type verdict;
      logic [15:0] port;
      logic [7:0]  url_len;
      logic [63:0] url_hash;
      logic [63:0] frames;
   } verdict_beat_type;

   verdict_beat_type expected_verdicts[$];

   logic [15:0] port_a, port_b, port_c;
   logic [15:0] pos;
   logic [3:0]  ihl_words, doff_words;
   logic [15:0] port_word;
   logic [31:0] shift_word;
   logic [8:0]  url_bytes;
   logic [63:0] url_fnv;
   phase_type   phase;
   verdict_type held;
   logic [63:0] frame_total;

   task automatic clear_parse();
      pos        = '0;
      ihl_words  = '0;
      doff_words = '0;
      port_word  = '0;
      shift_word = '0;
      url_bytes  = '0;
      url_fnv    = FNV_BASIS;
      phase      = PH_ETH;
      held       = V_MALFORMED;
   endtask

   task automatic decide(input verdict_type v);
      held  = v;
      phase = PH_DONE;
   endtask

   task automatic enter(input phase_type next);
      phase      = next;
      pos        = '0;
      shift_word = '0;
   endtask

   task automatic parse_frame_byte(input logic [7:0] b);
      logic [15:0] p;
      phase_type   ph;
      logic        halted;
      p      = pos;
      ph     = phase;
      halted = 1'b0;
      case (ph)
         PH_ETH: begin
            shift_word = {shift_word[23:0], b};
            if (p == 16'd13) begin
               if (shift_word[15:0] != ETHERTYPE_IPV4) decide(V_NOT_IPV4);
               else enter(PH_IP);
            end
         end
         PH_IP: begin
            if (p == 16'd0) begin
               ihl_words = b[3:0];
               if (b[3:0] < 4'd5) begin
                  decide(V_MALFORMED);
                  halted = 1'b1;
               end
            end
            if (!halted) begin
               if (p == 16'd9) shift_word = (b != PROTO_TCP) ? 32'd1 : 32'd0;
               if (p == 16'd19 && shift_word != 0) decide(V_NOT_TCP);
               else if (p >= 16'd19 && int'(p) == int'(ihl_words) * 4 - 1) enter(PH_TCP);
            end
         end
         PH_TCP: begin
            if (p == 16'd2 || p == 16'd3) shift_word = {shift_word[23:0], b};
            if (p == 16'd12) doff_words = b[7:4];
            if (p == 16'd19) begin
               port_word = shift_word[15:0];
               if (port_word != port_a && port_word != port_b && port_word != port_c) begin
                  decide(V_UNWATCHED);
                  halted = 1'b1;
               end else if (doff_words < 4'd5) begin
                  decide(V_MALFORMED);
                  halted = 1'b1;
               end
            end
            if (!halted && p >= 16'd19 && int'(p) == int'(doff_words) * 4 - 1)
               enter(PH_METHOD);
         end
         PH_METHOD: begin
            shift_word = {shift_word[23:0], b};
            if (p == 16'd3) begin
               if (shift_word == METHOD_GET) begin
                  enter(PH_URL);
                  url_bytes = '0;
                  url_fnv   = FNV_BASIS;
                  held      = V_EMPTY_URL;
               end else begin
                  decide(V_NOT_GET);
               end
            end
         end
         PH_URL: begin
            if (b == CHAR_SP || b == CHAR_CR || b == CHAR_LF) begin
               phase = PH_DONE;
            end else begin
               url_fnv   = (url_fnv ^ {56'd0, b}) * HASH_MULT;
               url_bytes = url_bytes + 9'd1;
               held      = V_GET;
               if (int'(url_bytes) >= URL_LIMIT) phase = PH_DONE;
            end
         end
         default: ;
      endcase
      if (phase == ph && pos != 16'hFFFF) pos = pos + 16'd1;
   endtask

   task automatic report_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
   endtask

   always @(posedge clock) begin : monitor
      verdict_beat_type exp_beat;
      logic             bad;
      if (reset) begin
         port_a      = PORT_A_RESET;
         port_b      = PORT_B_RESET;
         port_c      = PORT_C_RESET;
         frame_total = '0;
         clear_parse();
         expected_verdicts.delete();
         fail_count    <= 0;
         pending       <= 0;
         checked       <= 0;
         verdicts_seen <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_PORT_A: port_a = csr_wdata;
               REG_PORT_B: port_b = csr_wdata;
               REG_PORT_C: port_c = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            parse_frame_byte(req_tdata);
            if (req_tlast) begin
               frame_total       = frame_total + 64'd1;
               exp_beat.verdict  = held;
               exp_beat.port     = port_word;
               exp_beat.url_len  = (held == V_GET) ? url_bytes[7:0] : 8'd0;
               exp_beat.url_hash = (held == V_GET) ? url_fnv : 64'd0;
               exp_beat.frames   = frame_total;
               expected_verdicts.push_back(exp_beat);
               clear_parse();
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            bad = 1'b0;
            if (expected_verdicts.size() == 0) begin
               $display("%0t: verdict beat with nothing expected, actual verdict %0d",
                        $time, rsp_tuser);
               bad = 1'b1;
            end else begin
               exp_beat = expected_verdicts.pop_front();
               if (rsp_tuser !== exp_beat.verdict) begin
                  report_field("verdict", 64'(exp_beat.verdict), 64'(rsp_tuser));
                  bad = 1'b1;
               end
               if (rsp_tdata[15:0] !== exp_beat.port) begin
                  report_field("dest_port", 64'(exp_beat.port), 64'(rsp_tdata[15:0]));
                  bad = 1'b1;
               end
               if (rsp_tdata[23:16] !== exp_beat.url_len) begin
                  report_field("url_length", 64'(exp_beat.url_len), 64'(rsp_tdata[23:16]));
                  bad = 1'b1;
               end
               if (rsp_tdata[87:24] !== exp_beat.url_hash) begin
                  report_field("url_hash", exp_beat.url_hash, rsp_tdata[87:24]);
                  bad = 1'b1;
               end
               if (rsp_tdata[151:88] !== exp_beat.frames) begin
                  report_field("frames_seen", exp_beat.frames, rsp_tdata[151:88]);
                  bad = 1'b1;
               end
            end
            if (bad) fail_count <= fail_count + 1;
            checked <= checked + 1;
            if (rsp_tuser < 3'd7) verdicts_seen[rsp_tuser] <= 1'b1;
         end
         pending <= expected_verdicts.size();
      end
   end

endmodule

[tb/http_get_url_classifier_top_tb.sv]
// Testbench top for the HTTP GET URL classifier: frame stimulus, flow control, verdict.
`timescale 1ns / 1ps

module http_get_url_classifier_top_tb;
   import hgu_pkg::*;

   localparam int          CYCLE_LIMIT    = 400000;
   localparam int          LONG_HOLD      = 400;
   localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;
   localparam logic [31:0] METHOD_POST    = 32'h504F5354;
   localparam logic [15:0] PORT_HTTPS     = 16'd443;

   typedef enum int {END_NONE, END_SP, END_CR, END_LF} url_end_type;
   typedef enum logic [1:0] {RX_STEADY, RX_MOSTLY, RX_HALF, RX_SPARSE} rx_mode_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         csr_we     = 1'b0;
   logic [1:0]   csr_index  = REG_PORT_A;
   logic [15:0]  csr_wdata  = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata  = '0;
   logic         req_tlast  = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [151:0] rsp_tdata;
   logic [2:0]   rsp_tuser;

   int         fail_count, pending_verdicts, checked_verdicts;
   logic [6:0] verdicts_seen;

   logic [7:0]  frame_q[$];
   logic [15:0] port_a = PORT_A_RESET, port_b = PORT_B_RESET, port_c = PORT_C_RESET;
   int          burst_left = 0;
   int          bytes_sent = 0;
   int          frames_sent = 0;
   int          settings_used = 1;
   int          cycle_count = 0;

   logic        hold_go = 1'b0;
   logic        hold_taken;
   int          hold_left, stall_left;
   rx_mode_type stall_mode;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   http_get_url_classifier_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   hgu_verdict_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (fail_count),
      .pending       (pending_verdicts),
      .checked       (checked_verdicts),
      .verdicts_seen (verdicts_seen)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[http_get_url_classifier_top] ERROR");
         $finish;
      end
   end

   // result side: one long hold on request, otherwise segments of varying readiness
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
         hold_taken <= 1'b0;
         stall_left <= 0;
         stall_mode <= RX_STEADY;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_go && !hold_taken) begin
         rsp_tready <= 1'b0;
         hold_left  <= LONG_HOLD;
         hold_taken <= 1'b1;
      end else begin
         if (stall_left == 0) begin
            stall_left <= $urandom_range(4, 80);
            stall_mode <= rx_mode_type'($urandom_range(0, 3));
         end else begin
            stall_left <= stall_left - 1;
         end
         case (stall_mode)
            RX_STEADY: rsp_tready <= 1'b1;
            RX_MOSTLY: rsp_tready <= ($urandom_range(0, 3) != 0);
            RX_HALF:   rsp_tready <= ($urandom_range(0, 1) != 0);
            default:   rsp_tready <= ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic is_last);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left = burst_left - 1;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= is_last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent = bytes_sent + 1;
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_q.size(); i++) send_byte(frame_q[i], i == frame_q.size() - 1);
      frames_sent = frames_sent + 1;
   endtask

   task automatic send_ip_frame(input logic [15:0] ethertype, input int ihl,
                                input logic [7:0] proto, input logic [15:0] port,
                                input int doff, input logic [31:0] method,
                                input int url_len, input url_end_type ending,
                                input int tail, input int cut);
      int         ip_len, tcp_len;
      logic [7:0] c;
      logic [3:0] nib;
      frame_q.delete();
      repeat (12) frame_q.push_back(rand_byte());
      frame_q.push_back(ethertype[15:8]);
      frame_q.push_back(ethertype[7:0]);
      ip_len = (ihl < 5) ? 20 : ihl * 4;
      for (int i = 0; i < ip_len; i++) begin
         nib = 4'($urandom_range(0, 15));
         if (i == 0) frame_q.push_back({nib, 4'(ihl)});
         else if (i == 9) frame_q.push_back(proto);
         else frame_q.push_back(rand_byte());
      end
      tcp_len = (doff < 5) ? 20 : doff * 4;
      for (int i = 0; i < tcp_len; i++) begin
         nib = 4'($urandom_range(0, 15));
         if (i == 2) frame_q.push_back(port[15:8]);
         else if (i == 3) frame_q.push_back(port[7:0]);
         else if (i == 12) frame_q.push_back({4'(doff), nib});
         else frame_q.push_back(rand_byte());
      end
      frame_q.push_back(method[31:24]);
      frame_q.push_back(method[23:16]);
      frame_q.push_back(method[15:8]);
      frame_q.push_back(method[7:0]);
      for (int i = 0; i < url_len; i++) begin
         do c = rand_byte(); while (c == CHAR_SP || c == CHAR_CR || c == CHAR_LF);
         frame_q.push_back(c);
      end
      case (ending)
         END_SP:  frame_q.push_back(CHAR_SP);
         END_CR:  frame_q.push_back(CHAR_CR);
         END_LF:  frame_q.push_back(CHAR_LF);
         default: ;
      endcase
      repeat (tail) frame_q.push_back(rand_byte());
      if (cut > 0) while (frame_q.size() > cut) void'(frame_q.pop_back());
      send_frame();
   endtask

   task automatic send_fill_frame(input logic [7:0] fill, input int len);
      frame_q.delete();
      repeat (len) frame_q.push_back(fill);
      send_frame();
   endtask

   task automatic wait_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_verdicts != 0) @(posedge clock);
   endtask

   task automatic set_ports(input logic [15:0] a, input logic [15:0] b, input logic [15:0] c);
      wait_results();
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= REG_PORT_A;
      csr_wdata <= a;
      @(posedge clock);
      csr_index <= REG_PORT_B;
      csr_wdata <= b;
      @(posedge clock);
      csr_index <= REG_PORT_C;
      csr_wdata <= c;
      @(posedge clock);
      csr_we <= 1'b0;
      port_a = a;
      port_b = b;
      port_c = c;
      settings_used = settings_used + 1;
   endtask

   task automatic random_frame();
      int          pick, url_len, tail, cut;
      int          ihl, doff;
      logic [15:0] etype, port;
      logic [7:0]  proto;
      logic [31:0] method;
      url_end_type ending;
      pick    = $urandom_range(0, 99);
      etype   = ETHERTYPE_IPV4;
      ihl     = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5;
      doff    = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5;
      proto   = PROTO_TCP;
      method  = METHOD_GET;
      url_len = ($urandom_range(0, 19) == 0) ? $urandom_range(150, 230) : $urandom_range(1, 24);
      ending  = url_end_type'($urandom_range(0, 3));
      tail    = $urandom_range(0, 8);
      cut     = 0;
      case ($urandom_range(0, 2))
         0:       port = port_a;
         1:       port = port_b;
         default: port = port_c;
      endcase
      if (pick < 55) begin
      end else if (pick < 60) begin
         etype = 16'($urandom_range(0, 65535));
      end else if (pick < 64) begin
         ihl = $urandom_range(0, 4);
      end else if (pick < 69) begin
         proto = rand_byte();
         if (proto == PROTO_TCP) proto = PROTO_UDP;
      end else if (pick < 75) begin
         port = 16'($urandom_range(0, 65535));
      end else if (pick < 79) begin
         doff = $urandom_range(0, 4);
      end else if (pick < 84) begin
         method = ($urandom_range(0, 1) == 0) ? METHOD_GET ^ (32'd1 << $urandom_range(0, 31))
                                              : $urandom();
      end else if (pick < 89) begin
         url_len = 0;
         if (ending == END_NONE) ending = END_SP;
      end else if (pick < 96) begin
         cut = $urandom_range(1, 70);
      end
      if (pick >= 96) begin
         frame_q.delete();
         repeat ($urandom_range(1, 40)) frame_q.push_back(rand_byte());
         send_frame();
      end else begin
         send_ip_frame(etype, ihl, proto, port, doff, method, url_len, ending, tail, cut);
      end
   endtask

   task automatic run_random(input int min_bytes, input int min_frames);
      int start_bytes, start_frames;
      start_bytes  = bytes_sent;
      start_frames = frames_sent;
      while (bytes_sent - start_bytes < min_bytes || frames_sent - start_frames < min_frames)
      begin
         if ($urandom_range(0, 14) == 0) wait_results();
         random_frame();
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset   <= 1'b0;
      hold_go <= 1'b1;

      // directed frames on the reset port set
      send_ip_frame(ETHERTYPE_IPV4, 5, PROTO_TCP, PORT_A_RESET, 5, METHOD_GET, 1, END_SP, 4, 0);
      send_ip_frame(ETHERTYPE_IPV4, 15, PROTO_TCP, PORT_B_RESET, 15, METHOD_GET, 12, END_CR, 2, 0);
      send_ip_frame(ETHERTYPE_IPV4, 5, PROTO_TCP, PORT_C_RESET, 5, METHOD_GET, 7, END_LF, 0, 0);
      send_ip_frame(ETHERTYPE_IPV6, 5, PROTO_TCP, PORT_A_RESET, 5, METHOD_GET, 3, END_SP, 0, 0);
      send_ip_frame(ETHERTYPE_IPV4, 4, PROTO_TCP, PORT_A_RESET, 5, METHOD_GET, 3, END_SP, 0, 0);
      send_ip_frame(ETHERTYPE_IPV4, 0, PROTO_TCP, PORT_A_RESET, 5, METHOD_GET, 3, END_SP, 0, 0);
      send_ip_frame(ETHERTYPE_IPV4, 5, PROTO_UDP, PORT_A_RESET, 5, METHOD_GET, 3, END_SP, 0, 0);
      // non-TCP frame that ends before the IP header is complete
      send_ip_frame(ETHERTYPE_IPV4, 5, PROTO_UDP, PORT_A_RESET, 5, METHOD_GET, 3, END_SP, 0, 33);
      send_ip_frame(ETHERTYPE_IPV4, 5, PROTO_TCP, PORT_HTTPS, 5, METHOD_GET, 3, END_SP, 0, 0);
      send_ip_frame(ETHERTYPE_IPV4, 5, PROTO_TCP, PORT_B_RESET, 4, METHOD_GET, 3, END_SP, 0, 0);
      // port check wins over a bad data offset
      send_ip_frame(ETHERTYPE_IPV4, 5, PROTO_TCP, PORT_HTTPS, 0, METHOD_GET, 3, END_SP, 0, 0);
      send_ip_frame(ETHERTYPE_IPV4, 5, PROTO_TCP, PORT_A_RESET, 5, METHOD_POST, 3, END_SP, 0, 0);
      send_ip_frame(ETHERTYPE_IPV4, 5, PROTO_TCP, PORT_A_RESET, 5, METHOD_GET, 0, END_SP, 3, 0);
      send_ip_frame(ETHERTYPE_IPV4, 5, PROTO_TCP, PORT_C_RESET, 5, METHOD_GET, 200, END_NONE, 5, 0);
      send_ip_frame(ETHERTYPE_IPV4, 5, PROTO_TCP, PORT_A_RESET, 5, METHOD_GET, 6, END_NONE, 0, 0);
      send_ip_frame(ETHERTYPE_IPV4, 5, PROTO_TCP, PORT_A_RESET, 5, METHOD_GET, 6, END_SP, 0, 1);
      send_ip_frame(ETHERTYPE_IPV4, 5, PROTO_TCP, PORT_A_RESET, 5, METHOD_GET, 6, END_SP, 0, 13);
      send_ip_frame(ETHERTYPE_IPV4, 5, PROTO_TCP, PORT_A_RESET, 5, METHOD_GET, 6, END_SP, 0, 14);
      send_ip_frame(ETHERTYPE_IPV4, 5, PROTO_TCP, PORT_A_RESET, 5, METHOD_GET, 6, END_SP, 0, 36);
      send_ip_frame(ETHERTYPE_IPV4, 5, PROTO_TCP, PORT_A_RESET, 5, METHOD_GET, 6, END_SP, 0, 56);
      send_fill_frame(8'h00, 20);
      send_fill_frame(8'hFF, 20);

      set_ports(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)));
      run_random(100, 2);

      set_ports(16'h0000, 16'hFFFF, 16'h8000);
      run_random(100, 2);

      begin : same_ports
         logic [15:0] shared;
         shared = 16'($urandom_range(0, 65535));
         set_ports(shared, shared, shared);
      end
      run_random(100, 2);

      set_ports(16'hFFFF, 16'h0001, 16'h0000);
      run_random(100, 2);

      wait_results();
      repeat (10) @(posedge clock);
      $display("Sent %0d frames (%0d bytes) under %0d watched-port settings; %0d verdicts checked.",
               frames_sent, bytes_sent, settings_used, checked_verdicts);
      $display("Verdict codes seen, code 6 down to code 0: %b", verdicts_seen);
      if (fail_count == 0) begin
         $display("[http_get_url_classifier_top] OK");
      end else begin
         $display("[http_get_url_classifier_top] ERROR");
      end
      $finish;
   end

endmodule

[sim.f]
hdl/hgu_pkg.sv
hdl/hgu_front.sv
hdl/hgu_queue.sv
hdl/hgu_back.sv
hdl/http_get_url_classifier_top.sv
tb/hgu_verdict_checker.sv
tb/http_get_url_classifier_top_tb.sv
